// ===== sv/yuv2rgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv2rgb_pkg: shared types and constants for the YUYV to RGB converter
// Coefficients are Q16 fixed point, rounded to nearest. Chroma products are
// carried as signed terms; per-pixel sums are one bit wider.
// ----------------------------------------------------------------------------
package yuv2rgb_pkg;

	localparam int COEF_W = 18;
	localparam int TERM_W = 25;
	localparam int SUM_W  = 26;

	localparam logic signed [COEF_W-1:0] COEF_R_CR = 18'sd89831;
	localparam logic signed [COEF_W-1:0] COEF_G_CB = 18'sd22127;
	localparam logic signed [COEF_W-1:0] COEF_G_CR = 18'sd45744;
	localparam logic signed [COEF_W-1:0] COEF_B_CB = 18'sd113538;

	localparam logic [7:0] CHROMA_BIAS = 8'd128;
	localparam logic [7:0] CHAN_MAX    = 8'd255;
	localparam logic [8:0] GAIN_RESET  = 9'd220;

	// register indexes
	localparam logic REG_BYTE_ORDER = 1'b0;
	localparam logic REG_GAIN       = 1'b1;

	// byte order codes
	localparam logic ORDER_YUYV = 1'b0;
	localparam logic ORDER_UYVY = 1'b1;

	typedef logic [7:0] chan_t;
	typedef logic [8:0] gain_t;
	typedef logic signed [TERM_W-1:0] term_t;

	typedef struct packed {
		term_t r_cr;
		term_t g_cb;
		term_t g_cr;
		term_t b_cb;
	} chroma_terms_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_t;

	// signed chroma difference times Q16 coefficient
	function automatic term_t mul_coef(input logic signed [8:0] d,
			input logic signed [COEF_W-1:0] c);
		logic signed [COEF_W+8:0] p;
		p = d * c;
		return term_t'(p);
	endfunction

endpackage

// ===== sv/yuv2rgb_chroma.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv2rgb_chroma: byte unpack and shared chroma products
// Picks luma and chroma out of the four stream bytes and forms the four
// chroma products that both pixel lanes share. Registered as stage 1.
// ----------------------------------------------------------------------------
module yuv2rgb_chroma import yuv2rgb_pkg::*; (
	input  logic          clk,
	input  logic          load_s1,
	input  logic          byte_order,
	input  chan_t         stream_byte_0,
	input  chan_t         stream_byte_1,
	input  chan_t         stream_byte_2,
	input  chan_t         stream_byte_3,
	output chan_t         luma0_s1,
	output chan_t         luma1_s1,
	output chroma_terms_t terms_s1
);

	chan_t luma0, luma1, cb, cr;
	logic signed [8:0] du, dv;
	chroma_terms_t terms;

	// unpack by byte order
	always_comb begin
		if (byte_order == ORDER_UYVY) begin
			cb    = stream_byte_0;
			luma0 = stream_byte_1;
			cr    = stream_byte_2;
			luma1 = stream_byte_3;
		end else begin
			luma0 = stream_byte_0;
			cb    = stream_byte_1;
			luma1 = stream_byte_2;
			cr    = stream_byte_3;
		end
	end

	// remove chroma bias
	assign du = $signed({1'b0, cb}) - $signed({1'b0, CHROMA_BIAS});
	assign dv = $signed({1'b0, cr}) - $signed({1'b0, CHROMA_BIAS});

	// form the shared products
	assign terms.r_cr = mul_coef(dv, COEF_R_CR);
	assign terms.g_cb = mul_coef(du, COEF_G_CB);
	assign terms.g_cr = mul_coef(dv, COEF_G_CR);
	assign terms.b_cb = mul_coef(du, COEF_B_CB);

	// capture stage 1
	always_ff @(posedge clk) begin
		if (load_s1) begin
			luma0_s1 <= luma0;
			luma1_s1 <= luma1;
			terms_s1 <= terms;
		end
	end

endmodule

// ===== sv/yuv2rgb_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv2rgb_lane: one pixel of the pair
// Adds luma to the shared chroma terms, truncates and clamps each channel
// (stage 2 register), then applies the brightness gain with saturation.
// ----------------------------------------------------------------------------
module yuv2rgb_lane import yuv2rgb_pkg::*; (
	input  logic          clk,
	input  logic          load_s2,
	input  chan_t         luma_s1,
	input  chroma_terms_t terms_s1,
	input  gain_t         gain,
	output rgb_t          rgb
);

	logic signed [SUM_W-1:0] base, sum_r, sum_g, sum_b;
	rgb_t clamped, rgb_s2;

	// truncate Q16 toward zero and clamp to 0..255
	function automatic chan_t clamp_chan(input logic signed [SUM_W-1:0] s);
		logic [SUM_W-18:0] v;
		v = s[SUM_W-2:16];
		if (s[SUM_W-1])
			return '0;
		else if (v > {1'b0, CHAN_MAX})
			return CHAN_MAX;
		else
			return v[7:0];
	endfunction

	// scale by gain / 256 with floor, saturate
	function automatic chan_t gain_chan(input chan_t c, input gain_t g);
		logic [16:0] p;
		logic [8:0]  q;
		p = 17'(c) * 17'(g);
		q = p[16:8];
		if (q > {1'b0, CHAN_MAX})
			return CHAN_MAX;
		else
			return q[7:0];
	endfunction

	// channel sums
	assign base  = $signed({2'b00, luma_s1, 16'h0000});
	assign sum_r = base + SUM_W'(terms_s1.r_cr);
	assign sum_g = base - SUM_W'(terms_s1.g_cb) - SUM_W'(terms_s1.g_cr);
	assign sum_b = base + SUM_W'(terms_s1.b_cb);

	assign clamped.red   = clamp_chan(sum_r);
	assign clamped.green = clamp_chan(sum_g);
	assign clamped.blue  = clamp_chan(sum_b);

	// capture stage 2
	always_ff @(posedge clk) begin
		if (load_s2) begin
			rgb_s2 <= clamped;
		end
	end

	// apply brightness
	assign rgb.red   = gain_chan(rgb_s2.red,   gain);
	assign rgb.green = gain_chan(rgb_s2.green, gain);
	assign rgb.blue  = gain_chan(rgb_s2.blue,  gain);

endmodule

// ===== sv/yuyv_to_rgb_pixel_pair.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_to_rgb_pixel_pair: 4:2:2 macropixel to two RGB888 pixels
// Takes one request of four stream bytes per clock while in_ready is high
// and returns two pixels that share the chroma pair. Throughput is one
// macropixel per cycle while the output is not stalled. A request passes
// through three registered stages in order (unpack and chroma products,
// per-lane sum and clamp, brightness gain into the output register). Each of the two pixel
// lanes has its own adders and gain multipliers, and every stage holds under
// backpressure; a stalled output stops the input only once all three stages
// are full, and from then on in_ready follows out_ready in the same cycle.
// Register 0 selects YUYV (0) or UYVY (1) byte order; register 1 is the
// brightness gain in 1/256 units, reset 220. The user must write registers
// only while no request is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_pixel_pair import yuv2rgb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] stream_byte_0,
	input  logic [7:0] stream_byte_1,
	input  logic [7:0] stream_byte_2,
	input  logic [7:0] stream_byte_3,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] red_a,
	output logic [7:0] green_a,
	output logic [7:0] blue_a,
	output logic [7:0] red_b,
	output logic [7:0] green_b,
	output logic [7:0] blue_b
);

	logic          byte_order_q;
	gain_t         gain_q;
	logic          v1_q, v2_q, out_valid_q;
	logic          out_free, rdy2, load_s1, load_s2, load_out;
	chan_t         luma0_s1, luma1_s1;
	chroma_terms_t terms_s1;
	rgb_t          lane_a, lane_b, pix_a_q, pix_b_q;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_order_q <= ORDER_YUYV;
			gain_q       <= GAIN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BYTE_ORDER: byte_order_q <= cfg_data[0];
				REG_GAIN:       gain_q       <= cfg_data;
				default:        ;
			endcase
		end
	end

	// stage handshake: each stage advances when the next one is free
	assign out_free = !out_valid_q || out_ready;
	assign rdy2     = !v2_q || out_free;
	assign in_ready = !v1_q || rdy2;
	assign load_s1  = in_valid && in_ready;
	assign load_s2  = v1_q && rdy2;
	assign load_out = v2_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				v1_q <= in_valid;
			if (rdy2)
				v2_q <= v1_q;
			if (out_free)
				out_valid_q <= v2_q;
		end
	end

	// unpack and chroma products
	yuv2rgb_chroma u_chroma (
		.clk           (clk),
		.load_s1       (load_s1),
		.byte_order    (byte_order_q),
		.stream_byte_0 (stream_byte_0),
		.stream_byte_1 (stream_byte_1),
		.stream_byte_2 (stream_byte_2),
		.stream_byte_3 (stream_byte_3),
		.luma0_s1      (luma0_s1),
		.luma1_s1      (luma1_s1),
		.terms_s1      (terms_s1)
	);

	// pixel lanes
	yuv2rgb_lane u_lane_a (
		.clk      (clk),
		.load_s2  (load_s2),
		.luma_s1  (luma0_s1),
		.terms_s1 (terms_s1),
		.gain     (gain_q),
		.rgb      (lane_a)
	);

	yuv2rgb_lane u_lane_b (
		.clk      (clk),
		.load_s2  (load_s2),
		.luma_s1  (luma1_s1),
		.terms_s1 (terms_s1),
		.gain     (gain_q),
		.rgb      (lane_b)
	);

	// merge both lanes into the output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			pix_a_q <= lane_a;
			pix_b_q <= lane_b;
		end
	end

	assign out_valid = out_valid_q;
	assign red_a     = pix_a_q.red;
	assign green_a   = pix_a_q.green;
	assign blue_a    = pix_a_q.blue;
	assign red_b     = pix_b_q.red;
	assign green_b   = pix_b_q.green;
	assign blue_b    = pix_b_q.blue;

	// an accepted request occupies stage 1 next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 |=> v1_q)
		else $error("accepted request lost at stage 1");

	// a stalled stage 2 keeps its item
	assert property (@(posedge clk) disable iff (!arst_n)
		v2_q && !rdy2 |=> v2_q && $stable(lane_a) && $stable(lane_b))
		else $error("stage 2 changed while stalled");

	// zero gain gives black pixels
	assert property (@(posedge clk) disable iff (!arst_n)
		load_out && gain_q == '0 |=> red_a == '0 && green_a == '0 && blue_a == '0
			&& red_b == '0 && green_b == '0 && blue_b == '0)
		else $error("nonzero output with zero gain");

	// gain write lands in its register
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == REG_GAIN |=> gain_q == $past(cfg_data))
		else $error("gain register write lost");

endmodule

// ===== test/yuyv_to_rgb_pixel_pair_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_to_rgb_pixel_pair_test: self-checking bench for the macropixel converter
// Streams YUYV and UYVY macropixels into the converter under random idling on
// both handshakes and predicts each RGB pixel pair in fixed point from the
// current byte order and brightness gain. Every returned pair is checked field
// by field against the oldest prediction. Phases switch the registers while
// the pipe is empty, including gain 0, unity gain and gains that saturate.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_pixel_pair_test import yuv2rgb_pkg::*;;

	localparam int CLK_PERIOD         = 20;
	localparam int RESET_CYCLES       = 7;
	localparam int PIPE_LATENCY       = 3;
	localparam int LONG_HOLD          = 300;
	localparam int WATCHDOG_LIMIT     = 2000;
	localparam int RANDOM_PER_SETTING = 45;
	localparam int MAX_REPORTS        = 40;

	// Q16 conversion coefficients, rounded to nearest
	localparam longint Q16_R_CR = 89831;
	localparam longint Q16_G_CB = 22127;
	localparam longint Q16_G_CR = 45744;
	localparam longint Q16_B_CB = 113538;
	localparam longint CHROMA_MID = 128;
	localparam gain_t GAIN_AFTER_RESET = 9'd220;

	typedef struct packed {
		logic [7:0] b0, b1, b2, b3;
	} macropixel_t;

	typedef struct packed {
		rgb_t a;
		rgb_t b;
	} pixel_pair_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = 1'b0;
	logic [8:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] stream_byte_0 = '0;
	logic [7:0] stream_byte_1 = '0;
	logic [7:0] stream_byte_2 = '0;
	logic [7:0] stream_byte_3 = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] red_a, green_a, blue_a;
	logic [7:0] red_b, green_b, blue_b;

	macropixel_t macropixel_queue[$];
	pixel_pair_t pending_pairs[$];
	macropixel_t next_px;
	pixel_pair_t oldest_pair;

	logic  order_model;
	gain_t gain_model;
	logic  in_accepted = 1'b0;
	bit    src_idle_en = 1'b0;
	bit    sink_idle_en = 1'b0;
	int    src_gap = 0;
	int    sink_gap = 0;
	int    hold_requests = 0;
	int    hold_seen = 0;
	int    hold_left = 0;
	int    stall_cycles = 0;
	int    cfg_writes = 0;
	int    macropixels_sent = 0;
	int    pairs_checked = 0;
	int    errors = 0;

	yuyv_to_rgb_pixel_pair u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.stream_byte_0 (stream_byte_0),
		.stream_byte_1 (stream_byte_1),
		.stream_byte_2 (stream_byte_2),
		.stream_byte_3 (stream_byte_3),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.red_a         (red_a),
		.green_a       (green_a),
		.blue_a        (blue_a),
		.red_b         (red_b),
		.green_b       (green_b),
		.blue_b        (blue_b)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Truncate the Q16 sum, clamp, then apply gain with saturation
	function automatic chan_t finish_channel(input longint acc, input gain_t gain);
		longint level;
		if (acc < 0) begin
			level = 0;
		end else begin
			level = acc >>> 16;
			if (level > 255)
				level = 255;
		end
		level = (level * longint'(gain)) >>> 8;
		if (level > 255)
			level = 255;
		return chan_t'(level);
	endfunction

	function automatic rgb_t convert_pixel(input chan_t luma, input chan_t cb,
			input chan_t cr, input gain_t gain);
		longint base, du, dv;
		rgb_t px;
		base = longint'(luma) * 65536;
		du = longint'(cb) - CHROMA_MID;
		dv = longint'(cr) - CHROMA_MID;
		px.red   = finish_channel(base + Q16_R_CR * dv, gain);
		px.green = finish_channel(base - Q16_G_CB * du - Q16_G_CR * dv, gain);
		px.blue  = finish_channel(base + Q16_B_CB * du, gain);
		return px;
	endfunction

	// Unpack by byte order; both pixels share the chroma pair
	function automatic pixel_pair_t predict_pair(input macropixel_t m, input logic order,
			input gain_t gain);
		chan_t y0, y1, cb, cr;
		pixel_pair_t pair;
		if (order == ORDER_YUYV) begin
			y0 = m.b0; cb = m.b1; y1 = m.b2; cr = m.b3;
		end else begin
			cb = m.b0; y0 = m.b1; cr = m.b2; y1 = m.b3;
		end
		pair.a = convert_pixel(y0, cb, cr, gain);
		pair.b = convert_pixel(y1, cb, cr, gain);
		return pair;
	endfunction

	// Mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap(input bit enable);
		int roll;
		if (!enable)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Lean on the extremes and the chroma midpoint
	function automatic logic [7:0] draw_byte();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 8'd0;
		if (roll == 1)
			return 8'd255;
		if (roll == 2)
			return 8'($urandom_range(120, 136));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic check_field(input string field, input chan_t want_v, input chan_t got_v);
		if (want_v !== got_v) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %0d, actual %0d",
					$time, field, want_v, got_v);
		end
	endtask

	task automatic queue_bytes(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3);
		macropixel_queue.push_back({b0, b1, b2, b3});
	endtask

	task automatic queue_random(input int count);
		repeat (count)
			queue_bytes(draw_byte(), draw_byte(), draw_byte(), draw_byte());
	endtask

	// Issue one register request and hold it until taken
	task automatic write_reg(input logic idx, input logic [8:0] value);
		int start_count;
		start_count = cfg_writes;
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (cfg_writes == start_count);
		cfg_valid <= 1'b0;
	endtask

	// Wait for every queued request and every pixel pair, then let the pipe settle
	task automatic wait_drained();
		while (macropixel_queue.size() != 0 || in_valid || pending_pairs.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(negedge clk);
	endtask

	// Drive input requests from the queue at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_accepted) begin
			if (src_gap > 0) begin
				src_gap--;
				in_valid <= 1'b0;
			end else if (macropixel_queue.size() != 0) begin
				next_px = macropixel_queue.pop_front();
				stream_byte_0 <= next_px.b0;
				stream_byte_1 <= next_px.b1;
				stream_byte_2 <= next_px.b2;
				stream_byte_3 <= next_px.b3;
				in_valid <= 1'b1;
				src_gap = pick_gap(src_idle_en);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Drive output ready: long hold on request, else random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = LONG_HOLD - 1;
			out_ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			sink_gap = pick_gap(sink_idle_en);
		end
	end

	// Track registers, predict on input requests, check output pairs
	always @(posedge clk) begin
		if (!arst_n) begin
			in_accepted <= 1'b0;
			order_model = ORDER_YUYV;
			gain_model = GAIN_AFTER_RESET;
		end else begin
			in_accepted <= in_valid && in_ready;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_BYTE_ORDER)
					order_model = cfg_data[0];
				else if (cfg_index == REG_GAIN)
					gain_model = cfg_data;
				cfg_writes++;
			end
			if (in_valid && in_ready) begin
				pending_pairs.push_back(predict_pair(
					{stream_byte_0, stream_byte_1, stream_byte_2, stream_byte_3},
					order_model, gain_model));
				macropixels_sent++;
			end
			if (out_valid && out_ready) begin
				if (pending_pairs.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: pixel pair with none expected: %0d %0d %0d / %0d %0d %0d",
							$time, red_a, green_a, blue_a, red_b, green_b, blue_b);
				end else begin
					oldest_pair = pending_pairs.pop_front();
					check_field("red_a",   oldest_pair.a.red,   red_a);
					check_field("green_a", oldest_pair.a.green, green_a);
					check_field("blue_a",  oldest_pair.a.blue,  blue_a);
					check_field("red_b",   oldest_pair.b.red,   red_b);
					check_field("green_b", oldest_pair.b.green, green_b);
					check_field("blue_b",  oldest_pair.b.blue,  blue_b);
					pairs_checked++;
				end
			end
		end
	end

	// Abort when no request moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, stall_cycles);
			$display("yuyv_to_rgb_pixel_pair_test: FAIL");
			$finish;
		end
	end

	initial begin
		logic order_list [9];
		int   gain_list [9];

		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed: YUYV at unity gain, no idling
		write_reg(REG_BYTE_ORDER, {8'd0, ORDER_YUYV});
		write_reg(REG_GAIN, 9'd256);
		queue_bytes(8'd0,   8'd0,   8'd0,   8'd0);
		queue_bytes(8'd255, 8'd255, 8'd255, 8'd255);
		queue_bytes(8'd0,   8'd128, 8'd255, 8'd128);
		queue_bytes(8'd255, 8'd0,   8'd0,   8'd255);
		queue_bytes(8'd0,   8'd255, 8'd0,   8'd0);
		queue_bytes(8'd128, 8'd0,   8'd128, 8'd255);
		queue_bytes(8'd16,  8'd128, 8'd235, 8'd128);
		queue_bytes(8'hAA,  8'h55,  8'h55,  8'hAA);
		queue_bytes(8'd1,   8'd127, 8'd254, 8'd129);
		queue_bytes(8'd20,  8'd200, 8'd230, 8'd40);
		wait_drained();

		// Directed: gain above unity saturates
		write_reg(REG_GAIN, 9'd511);
		queue_bytes(8'd128, 8'd128, 8'd200, 8'd128);
		queue_bytes(8'd255, 8'd255, 8'd255, 8'd0);
		queue_bytes(8'd100, 8'd200, 8'd50,  8'd60);
		wait_drained();

		// Directed: zero gain blanks everything
		write_reg(REG_GAIN, 9'd0);
		queue_bytes(8'd255, 8'd255, 8'd255, 8'd255);
		queue_bytes(8'd128, 8'd128, 8'd128, 8'd128);
		wait_drained();

		// Directed: UYVY order at the reset gain
		write_reg(REG_BYTE_ORDER, {8'd0, ORDER_UYVY});
		write_reg(REG_GAIN, GAIN_AFTER_RESET);
		queue_bytes(8'd0,   8'd255, 8'd255, 8'd0);
		queue_bytes(8'd128, 8'd10,  8'd128, 8'd245);
		queue_bytes(8'd255, 8'd0,   8'd0,   8'd255);
		queue_bytes(8'h55,  8'hAA,  8'hAA,  8'h55);
		wait_drained();

		// Random phases over a spread of register settings
		order_list[0] = ORDER_YUYV; gain_list[0] = 220;
		order_list[1] = ORDER_UYVY; gain_list[1] = 220;
		order_list[2] = ORDER_UYVY; gain_list[2] = 0;
		order_list[3] = ORDER_YUYV; gain_list[3] = 511;
		order_list[4] = ORDER_UYVY; gain_list[4] = 256;
		order_list[5] = ORDER_YUYV; gain_list[5] = 1;
		order_list[6] = ORDER_UYVY; gain_list[6] = $urandom_range(257, 511);
		order_list[7] = ORDER_YUYV; gain_list[7] = $urandom_range(0, 256);
		order_list[8] = ORDER_UYVY; gain_list[8] = $urandom_range(0, 511);
		for (int k = 0; k < 9; k++) begin
			write_reg(REG_BYTE_ORDER, {8'd0, order_list[k]});
			write_reg(REG_GAIN, 9'(gain_list[k]));
			src_idle_en = (k % 3) != 1;
			sink_idle_en = (k % 3) != 2;
			queue_random(RANDOM_PER_SETTING);
			wait_drained();
		end

		// Stall the output for a long stretch while input keeps coming
		src_idle_en = 1'b0;
		sink_idle_en = 1'b1;
		hold_requests++;
		queue_random(40);
		wait_drained();

		// Resume after the sender paused for a full drain
		src_idle_en = 1'b1;
		queue_random(10);
		wait_drained();

		$display("Checked %0d pixel pairs from %0d macropixels after %0d register writes.",
			pairs_checked, macropixels_sent, cfg_writes);
		$display("Covered both byte orders, gains 0 to 511, a long output stall and idling.");
		if (errors == 0)
			$display("yuyv_to_rgb_pixel_pair_test: PASS");
		else
			$display("yuyv_to_rgb_pixel_pair_test: FAIL");
		$finish;
	end

endmodule
